/* sv/alkpc_pkg.sv */
// ----------------------------------------------------------------------------
// alkpc_pkg
// Types and constants for the two-channel ladder keypad classifier.
// ----------------------------------------------------------------------------
package alkpc_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd2;

  localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST   = 12'd2000;
  localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST    = 12'd1000;
  localparam logic [COUNT_W-1:0]  LONG_PRESS_TICKS_RST = 8'd100;
  localparam logic [COUNT_W-1:0]  COUNT_MAX            = 8'd255;

  localparam logic [1:0] KEY_A_HIGH = 2'd0;
  localparam logic [1:0] KEY_A_MID  = 2'd1;
  localparam logic [1:0] KEY_B_HIGH = 2'd2;
  localparam logic [1:0] KEY_B_MID  = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_HOLD_K0 = 3'd1,
    MODE_HOLD_K1 = 3'd2,
    MODE_HOLD_K2 = 3'd3,
    MODE_HOLD_K3 = 3'd4,
    MODE_CHECK_B = 3'd5
  } hold_mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0] key_number;
    logic       long_press;
  } out_item_t;

endpackage

/* sv/adc_ladder_key_press_classifier.sv */
// ----------------------------------------------------------------------------
// adc_ladder_key_press_classifier
// Classifies key holds on two resistor-ladder channels and reports each
// release with its key number and a long-press flag.
// A release result is in the output register in the cycle after the
// input transfer that ends the hold. Throughput: one input item per cycle;
// input is held off only while a result waits in the output register.
// Reset (rst_n low, synchronous): idle, count zero, no result pending,
// thresholds 2000/1000 and long-press count 100.
// ----------------------------------------------------------------------------
module adc_ladder_key_press_classifier (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  alkpc_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output alkpc_pkg::out_item_t                 out_data,
  input  logic                                 cfg_we,
  input  logic [alkpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [alkpc_pkg::CFG_W-1:0]          cfg_wdata
);

  logic [alkpc_pkg::SAMPLE_W-1:0] high_thr_r;
  logic [alkpc_pkg::SAMPLE_W-1:0] low_thr_r;
  logic [alkpc_pkg::COUNT_W-1:0]  long_ticks_r;

  alkpc_pkg::hold_mode_t          hold_mode_r, hold_mode_nxt;
  logic [alkpc_pkg::COUNT_W-1:0]  hold_count_r, hold_count_nxt;

  logic                           out_valid_r;
  alkpc_pkg::out_item_t           out_data_r;

  logic                           in_xfer;
  logic                           emit;
  alkpc_pkg::out_item_t           result;

  logic a_high, a_mid, b_high, b_mid;
  logic a_start, b_start;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign a_high  = in_data.sample_a > high_thr_r;
  assign a_mid   = (in_data.sample_a > low_thr_r) && (in_data.sample_a < high_thr_r);
  assign b_high  = in_data.sample_b > high_thr_r;
  assign b_mid   = (in_data.sample_b > low_thr_r) && (in_data.sample_b < high_thr_r);
  assign a_start = in_data.sample_a > low_thr_r;
  assign b_start = in_data.sample_b > low_thr_r;

  // next state
  always_comb begin
    hold_mode_nxt  = hold_mode_r;
    hold_count_nxt = hold_count_r;
    unique case (hold_mode_r)
      alkpc_pkg::MODE_HOLD_K0: begin
        if (a_high) begin
          hold_count_nxt = (hold_count_r == alkpc_pkg::COUNT_MAX) ? hold_count_r
                                                                   : hold_count_r + 8'd1;
        end else begin
          hold_mode_nxt  = alkpc_pkg::MODE_CHECK_B;
          hold_count_nxt = '0;
        end
      end
      alkpc_pkg::MODE_HOLD_K1: begin
        if (a_mid) begin
          hold_count_nxt = (hold_count_r == alkpc_pkg::COUNT_MAX) ? hold_count_r
                                                                   : hold_count_r + 8'd1;
        end else begin
          hold_mode_nxt  = alkpc_pkg::MODE_CHECK_B;
          hold_count_nxt = '0;
        end
      end
      alkpc_pkg::MODE_HOLD_K2: begin
        if (b_high) begin
          hold_count_nxt = (hold_count_r == alkpc_pkg::COUNT_MAX) ? hold_count_r
                                                                   : hold_count_r + 8'd1;
        end else begin
          hold_mode_nxt  = alkpc_pkg::MODE_IDLE;
          hold_count_nxt = '0;
        end
      end
      alkpc_pkg::MODE_HOLD_K3: begin
        if (b_mid) begin
          hold_count_nxt = (hold_count_r == alkpc_pkg::COUNT_MAX) ? hold_count_r
                                                                   : hold_count_r + 8'd1;
        end else begin
          hold_mode_nxt  = alkpc_pkg::MODE_IDLE;
          hold_count_nxt = '0;
        end
      end
      alkpc_pkg::MODE_CHECK_B: begin
        hold_count_nxt = '0;
        priority if (b_high) begin
          hold_mode_nxt = alkpc_pkg::MODE_HOLD_K2;
        end else if (b_start) begin
          hold_mode_nxt = alkpc_pkg::MODE_HOLD_K3;
        end else begin
          hold_mode_nxt = alkpc_pkg::MODE_IDLE;
        end
      end
      default: begin
        hold_count_nxt = '0;
        priority if (a_high) begin
          hold_mode_nxt = alkpc_pkg::MODE_HOLD_K0;
        end else if (a_start) begin
          hold_mode_nxt = alkpc_pkg::MODE_HOLD_K1;
        end else if (b_high) begin
          hold_mode_nxt = alkpc_pkg::MODE_HOLD_K2;
        end else if (b_start) begin
          hold_mode_nxt = alkpc_pkg::MODE_HOLD_K3;
        end else begin
          hold_mode_nxt = alkpc_pkg::MODE_IDLE;
          hold_count_nxt = hold_count_r;
        end
      end
    endcase
  end

  // release result
  always_comb begin
    emit              = 1'b0;
    result.key_number = alkpc_pkg::KEY_A_HIGH;
    result.long_press = hold_count_r >= long_ticks_r;
    unique case (hold_mode_r)
      alkpc_pkg::MODE_HOLD_K0: begin
        emit              = !a_high;
        result.key_number = alkpc_pkg::KEY_A_HIGH;
      end
      alkpc_pkg::MODE_HOLD_K1: begin
        emit              = !a_mid;
        result.key_number = alkpc_pkg::KEY_A_MID;
      end
      alkpc_pkg::MODE_HOLD_K2: begin
        emit              = !b_high;
        result.key_number = alkpc_pkg::KEY_B_HIGH;
      end
      alkpc_pkg::MODE_HOLD_K3: begin
        emit              = !b_mid;
        result.key_number = alkpc_pkg::KEY_B_MID;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r   <= alkpc_pkg::HIGH_THRESHOLD_RST;
      low_thr_r    <= alkpc_pkg::LOW_THRESHOLD_RST;
      long_ticks_r <= alkpc_pkg::LONG_PRESS_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        alkpc_pkg::CFG_HIGH_THRESHOLD:   high_thr_r   <= cfg_wdata;
        alkpc_pkg::CFG_LOW_THRESHOLD:    low_thr_r    <= cfg_wdata;
        alkpc_pkg::CFG_LONG_PRESS_TICKS: long_ticks_r <= cfg_wdata[alkpc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_mode_r  <= alkpc_pkg::MODE_IDLE;
      hold_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else if (in_xfer) begin
      hold_mode_r  <= hold_mode_nxt;
      hold_count_r <= hold_count_nxt;
      out_valid_r  <= emit;
    end else if (out_ready) begin
      out_valid_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/alkpc_checker.sv */
// ----------------------------------------------------------------------------
// alkpc_checker
// Port-level checks for the ladder keypad classifier, bound to the top level.
// ----------------------------------------------------------------------------
module alkpc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input alkpc_pkg::out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // a stalled result blocks input
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // a free output register never blocks input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output register");

  // a new result only follows an input transfer
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
    else $error("result without input transfer");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind adc_ladder_key_press_classifier alkpc_checker u_alkpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/tb_adc_ladder_key_press_classifier.sv */
// ----------------------------------------------------------------------------
// tb_adc_ladder_key_press_classifier
// Drives sample ticks for both ladder channels through the valid/ready input,
// mirrors the hold/release behavior of the classifier in a scoreboard and
// checks every released key and long-press flag in order. Phases change the
// thresholds and long-press count between idle points, with random gaps on
// both sides, a long output hold-off and a hold that saturates the count.
// ----------------------------------------------------------------------------
module tb_adc_ladder_key_press_classifier;
  import alkpc_pkg::*;

  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  typedef enum int {ZONE_LOW, ZONE_MID, ZONE_HIGH, ZONE_EDGE, ZONE_ANY} level_zone_t;

  class key_release_scoreboard;
    logic [SAMPLE_W-1:0] high_thr;
    logic [SAMPLE_W-1:0] low_thr;
    logic [COUNT_W-1:0]  long_ticks;
    hold_mode_t          mode;
    logic [COUNT_W-1:0]  held;
    out_item_t           pending[$];
    int                  errors;

    function new();
      high_thr   = HIGH_THRESHOLD_RST;
      low_thr    = LOW_THRESHOLD_RST;
      long_ticks = LONG_PRESS_TICKS_RST;
      mode       = MODE_IDLE;
      held       = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_HIGH_THRESHOLD:   high_thr = v[SAMPLE_W-1:0];
        CFG_LOW_THRESHOLD:    low_thr = v[SAMPLE_W-1:0];
        CFG_LONG_PRESS_TICKS: long_ticks = v[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_transfer(in_item_t it);
      logic [1:0]          key;
      logic [SAMPLE_W-1:0] s;
      logic                kept;
      out_item_t           r;
      case (mode)
        MODE_HOLD_K0, MODE_HOLD_K1, MODE_HOLD_K2, MODE_HOLD_K3: begin
          case (mode)
            MODE_HOLD_K0: key = KEY_A_HIGH;
            MODE_HOLD_K1: key = KEY_A_MID;
            MODE_HOLD_K2: key = KEY_B_HIGH;
            default:      key = KEY_B_MID;
          endcase
          s = (key == KEY_A_HIGH || key == KEY_A_MID) ? it.sample_a : it.sample_b;
          if (key == KEY_A_HIGH || key == KEY_B_HIGH)
            kept = s > high_thr;
          else
            kept = (s > low_thr) && (s < high_thr);
          if (kept) begin
            if (held != COUNT_MAX) held++;
          end else begin
            r.key_number = key;
            r.long_press = held >= long_ticks;
            pending.push_back(r);
            mode = (key == KEY_A_HIGH || key == KEY_A_MID) ? MODE_CHECK_B : MODE_IDLE;
            held = '0;
          end
        end
        default: begin
          if (mode != MODE_CHECK_B && it.sample_a > high_thr)
            mode = MODE_HOLD_K0;
          else if (mode != MODE_CHECK_B && it.sample_a > low_thr)
            mode = MODE_HOLD_K1;
          else if (it.sample_b > high_thr)
            mode = MODE_HOLD_K2;
          else if (it.sample_b > low_thr)
            mode = MODE_HOLD_K3;
          else
            mode = MODE_IDLE;
          held = '0;
        end
      endcase
    endfunction

    task report(string msg);
      if (errors < 50) $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_release(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected release key=%0d long=%0d",
                         got.key_number, got.long_press));
      end else begin
        exp_r = pending.pop_front();
        if (got.key_number !== exp_r.key_number)
          report($sformatf("key_number got %0d want %0d", got.key_number, exp_r.key_number));
        if (got.long_press !== exp_r.long_press)
          report($sformatf("long_press got %0d want %0d (key %0d)",
                           got.long_press, exp_r.long_press, exp_r.key_number));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_data;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  key_release_scoreboard  sb;
  bit                     idle_tx;
  bit                     idle_rx;
  int                     rx_hold_req;
  int                     phase_items;

  adc_ladder_key_press_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_release(out_data);
      if (in_valid && in_ready) sb.note_transfer(in_data);
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = idle_rx ? int'($urandom_range(12, 0)) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  function automatic logic [SAMPLE_W-1:0] level(level_zone_t z);
    int unsigned         hi;
    int unsigned         lo;
    logic [SAMPLE_W-1:0] r;
    hi = int'(sb.high_thr);
    lo = int'(sb.low_thr);
    r = SAMPLE_W'($urandom);
    case (z)
      ZONE_LOW:  r = SAMPLE_W'($urandom_range(lo, 0));
      ZONE_MID:  if (lo + 1 < hi) r = SAMPLE_W'($urandom_range(hi - 1, lo + 1));
      ZONE_HIGH: r = (hi < SAMPLE_MAX) ? SAMPLE_W'($urandom_range(SAMPLE_MAX, hi + 1))
                                       : SAMPLE_W'(SAMPLE_MAX);
      ZONE_EDGE: begin
        case ($urandom_range(3, 0))
          0:       r = SAMPLE_W'(lo);
          1:       r = SAMPLE_W'(lo + 1);
          2:       r = SAMPLE_W'(hi);
          default: r = SAMPLE_W'(hi + 1);
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic level_zone_t any_zone();
    return level_zone_t'($urandom_range(ZONE_ANY, ZONE_LOW));
  endfunction

  function automatic int hold_len();
    int lp;
    lp = int'(sb.long_ticks);
    if ($urandom_range(3, 0) == 0)
      return (lp > 2 ? lp - 2 : 0) + int'($urandom_range(4, 0));
    return int'($urandom_range(8, 0));
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = idle_tx ? int'($urandom_range(12, 0)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    phase_items++;
  endtask

  task automatic send_ab(input int unsigned a, input int unsigned b);
    in_item_t it;
    it.sample_a = SAMPLE_W'(a);
    it.sample_b = SAMPLE_W'(b);
    send_item(it);
  endtask

  // one press of a key: start tick, len held ticks, release tick
  task automatic play_press(input logic [1:0] key, input int len);
    in_item_t    it;
    level_zone_t hz;
    level_zone_t rz;
    bit          on_b;
    on_b = (key == KEY_B_HIGH || key == KEY_B_MID);
    hz = (key == KEY_A_MID || key == KEY_B_MID) ? ZONE_MID : ZONE_HIGH;
    if (on_b) begin
      it.sample_a = level(ZONE_LOW);
      it.sample_b = level(hz);
    end else begin
      it.sample_a = level(hz);
      it.sample_b = level(ZONE_ANY);
      if (key == KEY_A_MID && $urandom_range(3, 0) == 0) it.sample_a = sb.high_thr;
    end
    send_item(it);
    repeat (len) begin
      it.sample_a = on_b ? level(ZONE_ANY) : level(hz);
      it.sample_b = on_b ? level(hz) : level(ZONE_ANY);
      send_item(it);
    end
    case ($urandom_range(2, 0))
      0:       rz = ZONE_LOW;
      1:       rz = ZONE_EDGE;
      default: rz = (hz == ZONE_MID) ? ZONE_HIGH : ZONE_MID;
    endcase
    it.sample_a = on_b ? level(ZONE_ANY) : level(rz);
    it.sample_b = on_b ? level(rz) : level(ZONE_ANY);
    send_item(it);
  endtask

  task automatic write_config(input int unsigned hi, input int unsigned lo,
                              input int unsigned lp);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HIGH_THRESHOLD;
    cfg_wdata <= CFG_W'(hi);
    sb.set_reg(CFG_HIGH_THRESHOLD, CFG_W'(hi));
    @(posedge clk);
    cfg_index <= CFG_LOW_THRESHOLD;
    cfg_wdata <= CFG_W'(lo);
    sb.set_reg(CFG_LOW_THRESHOLD, CFG_W'(lo));
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS_TICKS;
    cfg_wdata <= CFG_W'(lp);
    sb.set_reg(CFG_LONG_PRESS_TICKS, CFG_W'(lp));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned hi, input int unsigned lo,
                           input int unsigned lp, input int n, input bit tx_gaps,
                           input bit rx_gaps, input int rx_hold, input int sat_len);
    in_item_t it;
    write_config(hi, lo, lp);
    idle_tx = tx_gaps;
    idle_rx = rx_gaps;
    rx_hold_req = rx_hold;
    phase_items = 0;
    if (sat_len > 0) play_press(KEY_A_HIGH, sat_len);
    while (phase_items < n) begin
      if ($urandom_range(4, 0) == 0) begin
        it.sample_a = level(any_zone());
        it.sample_b = level(any_zone());
        send_item(it);
      end else begin
        play_press(2'($urandom_range(3, 0)), hold_len());
      end
    end
    settle();
  endtask

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_HIGH_THRESHOLD;
    cfg_wdata <= '0;
    idle_tx = 1'b1;
    idle_rx = 1'b1;
    rx_hold_req = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: each key, boundary levels, channel B after an A release
    send_ab(4095, 0);    send_ab(2001, 0);    send_ab(2000, 0);
    send_ab(4095, 4095); send_ab(0, 4095);    send_ab(0, 0);
    send_ab(2000, 0);    send_ab(1001, 0);    send_ab(1999, 0);   send_ab(2000, 0);
    send_ab(0, 1001);    send_ab(0, 1999);    send_ab(0, 2000);
    send_ab(1000, 1000); send_ab(0, 0);
    send_ab(0, 2001);    send_ab(4095, 4095); send_ab(0, 2000);
    send_ab(1500, 4095); send_ab(4095, 0);    send_ab(0, 0);
    send_ab(2001, 4095); send_ab(0, 0);
    settle();

    run_phase(2000, 1000, 100, 60, 1'b1, 1'b1, 0, 0);
    run_phase(4095, 0, 1, 40, 1'b0, 1'b0, 0, 0);
    run_phase(0, 4095, 20, 40, 1'b1, 1'b0, 0, 0);
    run_phase(3000, 500, 0, 40, 1'b0, 1'b1, 0, 0);
    run_phase(2500, 1200, 5, 80, 1'b0, 1'b1, 80, 0);
    run_phase(1800, 600, 255, 10, 1'b1, 1'b1, 0, 260);
    run_phase(2000, 1999, 3, 40, 1'b1, 1'b1, 0, 0);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/alkpc_pkg.sv
sv/adc_ladder_key_press_classifier.sv
sv/alkpc_checker.sv
tb/tb_adc_ladder_key_press_classifier.sv
